// File: sv/sjfp_pkg.sv
// Shared constants and control types for the shortest-job-first picker.
`timescale 1ns / 1ps

package sjfp_pkg;

    // Default sizes
    localparam int DEPTH_DEF     = 16;
    localparam int PID_BITS_DEF  = 8;
    localparam int TIME_BITS_DEF = 16;

    // Exit state of the leaving task
    localparam logic [1:0] EXIT_READY    = 2'd0;
    localparam logic [1:0] EXIT_BLOCKED  = 2'd1;
    localparam logic [1:0] EXIT_FINISHED = 2'd2;
    localparam logic [1:0] EXIT_INVALID  = 2'd3;

    // Disposition codes reported with each result
    localparam int DISP_W = 3;
    localparam logic [DISP_W-1:0] DISP_NONE     = 3'd0;
    localparam logic [DISP_W-1:0] DISP_READY    = 3'd1;
    localparam logic [DISP_W-1:0] DISP_BLOCKED  = 3'd2;
    localparam logic [DISP_W-1:0] DISP_FINISHED = 3'd3;
    localparam logic [DISP_W-1:0] DISP_BAD      = 3'd4;

    // Commands from controller to datapath
    typedef struct packed {
        logic accept;       // capture item, push if ready, restart the walk
        logic scan_step;    // read next entry, keep the least remaining time
        logic shift_start;  // point the walk just past the chosen entry
        logic shift_step;   // move one entry down over the gap
        logic finish;       // load the result register, drop the chosen entry
    } ctl_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic walk_done;    // no read pending and no entry left to visit
        logic out_free;     // result register empty or being taken
    } ctl_status_t;

endpackage

// File: sv/sjfp_ctrl.sv
// Controller state machine for the shortest-job-first picker.
`timescale 1ns / 1ps

module sjfp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  sjfp_pkg::ctl_status_t status,
    output sjfp_pkg::ctl_cmd_t    cmd
);
    import sjfp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_SHIFT  = 4'b0100,
        S_FINISH = 4'b1000
    } ctl_state_t;

    ctl_state_t state_reg;
    ctl_state_t state_next;

    // Take an item only while idle
    assign in_stall = (state_reg != S_IDLE);

    // Sequence one call: scan, close the gap, deliver
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.walk_done)
                begin
                    cmd.shift_start = 1'b1;
                    state_next      = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                cmd.shift_step = 1'b1;
                if (status.walk_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: sv/sjfp_datapath.sv
// Datapath of the shortest-job-first picker: ready list memory, scan and result register.
`timescale 1ns / 1ps

module sjfp_datapath #(
    parameter int DEPTH     = sjfp_pkg::DEPTH_DEF,
    parameter int PID_BITS  = sjfp_pkg::PID_BITS_DEF,
    parameter int TIME_BITS = sjfp_pkg::TIME_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  sjfp_pkg::ctl_cmd_t              cmd,
    output sjfp_pkg::ctl_status_t           status,
    input  logic                            cur_valid,
    input  logic [1:0]                      cur_state,
    input  logic [PID_BITS-1:0]             cur_pid,
    input  logic [TIME_BITS-1:0]            cur_remaining,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            sel_valid,
    output logic [PID_BITS-1:0]             sel_pid,
    output logic [TIME_BITS-1:0]            sel_remaining,
    output logic [sjfp_pkg::DISP_W-1:0]     disposition,
    output logic                            overflow
);
    import sjfp_pkg::*;

    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int ENTRY_W = PID_BITS + TIME_BITS;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    // Ready list, arrival order, pid above remaining time
    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rdata_reg;

    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CNT_W-1:0]     ptr_reg, ptr_next;
    logic [CNT_W-1:0]     idx_d_reg, idx_d_next;
    logic                 rd_pend_reg, rd_pend_next;
    logic                 found_reg, found_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    logic [PID_BITS-1:0]  best_pid_reg, best_pid_next;
    logic [TIME_BITS-1:0] best_rem_reg, best_rem_next;
    logic [DISP_W-1:0]    disp_reg, disp_next;
    logic                 ovf_reg, ovf_next;

    logic                 out_valid_reg, out_valid_next;
    logic                 sel_valid_reg;
    logic [PID_BITS-1:0]  sel_pid_reg;
    logic [TIME_BITS-1:0] sel_rem_reg;
    logic [DISP_W-1:0]    sel_disp_reg;
    logic                 sel_ovf_reg;

    logic                 push;
    logic                 ptr_in_list;
    logic                 we;
    logic [IDX_W-1:0]     waddr;
    logic [ENTRY_W-1:0]   wdata;
    logic [CNT_W-1:0]     gap_idx;
    logic [PID_BITS-1:0]  rd_pid;
    logic [TIME_BITS-1:0] rd_rem;

    assign rd_pid      = rdata_reg[ENTRY_W-1:TIME_BITS];
    assign rd_rem      = rdata_reg[TIME_BITS-1:0];
    assign ptr_in_list = (ptr_reg < cnt_reg);
    assign push        = cmd.accept && cur_valid && (cur_state == EXIT_READY)
                         && (cnt_reg < DEPTH_CNT);
    assign gap_idx     = idx_d_reg - CNT_W'(1);

    assign status.walk_done = !ptr_in_list && !rd_pend_reg;
    assign status.out_free  = !out_valid_reg || !out_stall;

    // Classify the leaving task
    always_comb
    begin
        disp_next = disp_reg;
        ovf_next  = ovf_reg;
        if (cmd.accept)
        begin
            ovf_next = 1'b0;
            if (!cur_valid)
            begin
                disp_next = DISP_NONE;
            end
            else
            begin
                case (cur_state)
                    EXIT_READY:
                    begin
                        disp_next = DISP_READY;
                        ovf_next  = (cnt_reg >= DEPTH_CNT);
                    end
                    EXIT_BLOCKED:  disp_next = DISP_BLOCKED;
                    EXIT_FINISHED: disp_next = DISP_FINISHED;
                    EXIT_INVALID:  disp_next = DISP_BAD;
                    default:       disp_next = DISP_BAD;
                endcase
            end
        end
    end

    // Walk pointer, pending read and best-so-far
    always_comb
    begin
        ptr_next      = ptr_reg;
        idx_d_next    = ptr_reg;
        rd_pend_next  = (cmd.scan_step || cmd.shift_step) && ptr_in_list;
        found_next    = found_reg;
        best_idx_next = best_idx_reg;
        best_pid_next = best_pid_reg;
        best_rem_next = best_rem_reg;
        cnt_next      = cnt_reg;

        if (cmd.accept)
        begin
            ptr_next      = '0;
            found_next    = 1'b0;
            best_idx_next = '0;
            best_pid_next = '0;
            best_rem_next = '0;
            if (push)
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
        else if (cmd.shift_start)
        begin
            ptr_next = CNT_W'(best_idx_reg) + CNT_W'(1);
        end
        else if ((cmd.scan_step || cmd.shift_step) && ptr_in_list)
        begin
            ptr_next = ptr_reg + CNT_W'(1);
        end

        // Keep the least remaining time; strict compare keeps the oldest tie
        if (cmd.scan_step && rd_pend_reg)
        begin
            if (!found_reg || (rd_rem < best_rem_reg))
            begin
                found_next    = 1'b1;
                best_idx_next = idx_d_reg[IDX_W-1:0];
                best_pid_next = rd_pid;
                best_rem_next = rd_rem;
            end
        end

        if (cmd.finish && found_reg)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    // Memory write: append on push, move down while closing the gap
    always_comb
    begin
        we    = 1'b0;
        waddr = cnt_reg[IDX_W-1:0];
        wdata = {cur_pid, cur_remaining};
        if (push)
        begin
            we = 1'b1;
        end
        else if (cmd.shift_step && rd_pend_reg)
        begin
            we    = 1'b1;
            waddr = gap_idx[IDX_W-1:0];
            wdata = rdata_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[ptr_reg[IDX_W-1:0]];
    end

    // Result register handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            ptr_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            ptr_reg       <= ptr_next;
            rd_pend_reg   <= rd_pend_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_d_reg    <= idx_d_next;
        best_idx_reg <= best_idx_next;
        best_pid_reg <= best_pid_next;
        best_rem_reg <= best_rem_next;
        disp_reg     <= disp_next;
        ovf_reg      <= ovf_next;
        if (cmd.finish)
        begin
            sel_valid_reg <= found_reg;
            sel_pid_reg   <= best_pid_reg;
            sel_rem_reg   <= best_rem_reg;
            sel_disp_reg  <= disp_reg;
            sel_ovf_reg   <= ovf_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign sel_valid     = sel_valid_reg;
    assign sel_pid       = sel_pid_reg;
    assign sel_remaining = sel_rem_reg;
    assign disposition   = sel_disp_reg;
    assign overflow      = sel_ovf_reg;

endmodule

// File: sv/shortest_job_first_picker.sv
// Top level of the shortest-job-first picker: controller and datapath.
//
// Usage: each input item is one scheduler call, offered on in_valid with
// cur_valid, cur_state, cur_pid and cur_remaining; the block takes it when
// in_valid is high and in_stall is low. A task leaving as ready is appended
// to a ready list of DEPTH entries held in a single-port-read memory. The
// block then walks the list one entry a cycle to find the least remaining
// time (oldest wins a tie), walks again to move later entries down over the
// gap, and delivers exactly one result item on out_valid / out_stall.
// The block takes no new item until the last one's result is loaded; the pace
// of both walks is set by the memory's one read per cycle.
// The result sits in an output register: the next item is taken and worked
// on while a result waits, and only the final load waits for out_stall.
// Reset clears the list count and the control state; list contents need no
// clearing since only entries below the count are read.
`timescale 1ns / 1ps

module shortest_job_first_picker #(
    parameter int DEPTH     = sjfp_pkg::DEPTH_DEF,
    parameter int PID_BITS  = sjfp_pkg::PID_BITS_DEF,
    parameter int TIME_BITS = sjfp_pkg::TIME_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        cur_valid,
    input  logic [1:0]                  cur_state,
    input  logic [PID_BITS-1:0]         cur_pid,
    input  logic [TIME_BITS-1:0]        cur_remaining,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        sel_valid,
    output logic [PID_BITS-1:0]         sel_pid,
    output logic [TIME_BITS-1:0]        sel_remaining,
    output logic [sjfp_pkg::DISP_W-1:0] disposition,
    output logic                        overflow
);
    import sjfp_pkg::*;

    ctl_cmd_t    cmd;
    ctl_status_t status;

    sjfp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    sjfp_datapath #(
        .DEPTH     (DEPTH),
        .PID_BITS  (PID_BITS),
        .TIME_BITS (TIME_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cur_valid     (cur_valid),
        .cur_state     (cur_state),
        .cur_pid       (cur_pid),
        .cur_remaining (cur_remaining),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sel_valid     (sel_valid),
        .sel_pid       (sel_pid),
        .sel_remaining (sel_remaining),
        .disposition   (disposition),
        .overflow      (overflow)
    );

endmodule

// File: sv/sjfp_checker.sv
// Port-level checker for the shortest-job-first picker, bound to the top level.
`timescale 1ns / 1ps

module sjfp_checker #(
    parameter int PID_BITS  = sjfp_pkg::PID_BITS_DEF,
    parameter int TIME_BITS = sjfp_pkg::TIME_BITS_DEF
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic                        sel_valid,
    input logic [PID_BITS-1:0]         sel_pid,
    input logic [TIME_BITS-1:0]        sel_remaining,
    input logic [sjfp_pkg::DISP_W-1:0] disposition,
    input logic                        overflow
);
    import sjfp_pkg::*;

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // An accepted item keeps the block busy for the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("item taken without processing");

    // No selection reports zero pid and time
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !sel_valid |-> (sel_pid == '0) && (sel_remaining == '0))
        else $error("empty selection carries data");

    // Overflow only for a task leaving as ready
    a_ovf_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> (disposition == DISP_READY))
        else $error("overflow with wrong disposition");

    // Disposition is a defined code
    a_disp_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (disposition == DISP_NONE) || (disposition == DISP_READY)
                      || (disposition == DISP_BLOCKED) || (disposition == DISP_FINISHED)
                      || (disposition == DISP_BAD))
        else $error("undefined disposition code");

endmodule

bind shortest_job_first_picker sjfp_checker #(
    .PID_BITS  (PID_BITS),
    .TIME_BITS (TIME_BITS)
) u_sjfp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .sel_valid     (sel_valid),
    .sel_pid       (sel_pid),
    .sel_remaining (sel_remaining),
    .disposition   (disposition),
    .overflow      (overflow)
);

// File: sim/shortest_job_first_picker_tb.sv
// Self-checking testbench for the shortest-job-first picker: directed calls, then random calls.
`timescale 1ns / 1ps

module shortest_job_first_picker_tb;

    import sjfp_pkg::*;

    localparam int DEPTH     = DEPTH_DEF;
    localparam int PID_W     = PID_BITS_DEF;
    localparam int TIME_W    = TIME_BITS_DEF;
    localparam int N_RANDOM  = 1150;
    localparam int LATENCY   = 2 * DEPTH + 6;
    localparam int MAX_CYCLE = 400000;
    localparam int N_TABLE   = 20;

    // One selection result as the block reports it
    typedef struct packed {
        logic              sel_valid;
        logic [PID_W-1:0]  sel_pid;
        logic [TIME_W-1:0] sel_remaining;
        logic [DISP_W-1:0] disposition;
        logic              overflow;
    } pick_t;

    // One scheduler call, with an optional hand-written expectation
    typedef struct packed {
        logic              cur_valid;
        logic [1:0]        cur_state;
        logic [PID_W-1:0]  cur_pid;
        logic [TIME_W-1:0] cur_remaining;
        logic              has_pick;
        pick_t             pick;
    } sched_call_t;

    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              in_valid      = 1'b0;
    logic              in_stall;
    logic              cur_valid     = 1'b0;
    logic [1:0]        cur_state     = EXIT_READY;
    logic [PID_W-1:0]  cur_pid       = '0;
    logic [TIME_W-1:0] cur_remaining = '0;
    logic              out_valid;
    logic              out_stall     = 1'b0;
    logic              sel_valid;
    logic [PID_W-1:0]  sel_pid;
    logic [TIME_W-1:0] sel_remaining;
    logic [DISP_W-1:0] disposition;
    logic              overflow;

    // Ready list kept by the predictor
    logic [PID_W-1:0]  ready_pid [DEPTH];
    logic [TIME_W-1:0] ready_rem [DEPTH];
    int                ready_len = 0;

    sched_call_t call_q [$];
    pick_t       picks_due [$];
    sched_call_t call_held;
    int          call_idx   = 0;
    int          burst_left = 1;
    int          gap_left   = 0;
    int          mismatches = 0;
    int          cycle_count = 0;

    // Receiver stall pattern
    logic [15:0] stall_pattern = 16'h0000;
    logic [3:0]  stall_phase   = 4'd0;
    int          stall_span    = 0;

    // Directed calls: the whole range of each field, every exit state,
    // ignored fields on a call with no leaving task, and an empty list
    sched_call_t call_table [N_TABLE] = '{
        '{1'b0, EXIT_READY,    8'h00, 16'h0000, 1'b1, '{1'b0, 8'h00, 16'h0000, DISP_NONE,     1'b0}},
        '{1'b1, EXIT_READY,    8'hff, 16'hffff, 1'b1, '{1'b1, 8'hff, 16'hffff, DISP_READY,    1'b0}},
        '{1'b1, EXIT_READY,    8'h00, 16'h0000, 1'b1, '{1'b1, 8'h00, 16'h0000, DISP_READY,    1'b0}},
        '{1'b1, EXIT_BLOCKED,  8'hff, 16'hffff, 1'b1, '{1'b0, 8'h00, 16'h0000, DISP_BLOCKED,  1'b0}},
        '{1'b1, EXIT_FINISHED, 8'hff, 16'hffff, 1'b1, '{1'b0, 8'h00, 16'h0000, DISP_FINISHED, 1'b0}},
        '{1'b1, EXIT_INVALID,  8'hff, 16'hffff, 1'b1, '{1'b0, 8'h00, 16'h0000, DISP_BAD,      1'b0}},
        '{1'b1, EXIT_INVALID,  8'h00, 16'h0000, 1'b1, '{1'b0, 8'h00, 16'h0000, DISP_BAD,      1'b0}},
        '{1'b0, EXIT_INVALID,  8'hff, 16'hffff, 1'b1, '{1'b0, 8'h00, 16'h0000, DISP_NONE,     1'b0}},
        '{1'b0, EXIT_BLOCKED,  8'haa, 16'h5555, 1'b1, '{1'b0, 8'h00, 16'h0000, DISP_NONE,     1'b0}},
        '{1'b0, EXIT_FINISHED, 8'h55, 16'haaaa, 1'b1, '{1'b0, 8'h00, 16'h0000, DISP_NONE,     1'b0}},
        '{1'b1, EXIT_READY,    8'h01, 16'h0001, 1'b1, '{1'b1, 8'h01, 16'h0001, DISP_READY,    1'b0}},
        '{1'b1, EXIT_READY,    8'h80, 16'h8000, 1'b1, '{1'b1, 8'h80, 16'h8000, DISP_READY,    1'b0}},
        '{1'b1, EXIT_BLOCKED,  8'h00, 16'h0000, 1'b1, '{1'b0, 8'h00, 16'h0000, DISP_BLOCKED,  1'b0}},
        '{1'b1, EXIT_READY,    8'h7f, 16'h7fff, 1'b0, '0},
        '{1'b1, EXIT_READY,    8'ha5, 16'h1234, 1'b0, '0},
        '{1'b1, EXIT_READY,    8'h5a, 16'h0000, 1'b0, '0},
        '{1'b0, EXIT_READY,    8'h3c, 16'hc3c3, 1'b0, '0},
        '{1'b1, EXIT_FINISHED, 8'h0f, 16'hf0f0, 1'b0, '0},
        '{1'b1, EXIT_READY,    8'hf0, 16'h0f0f, 1'b0, '0},
        '{1'b1, EXIT_INVALID,  8'h69, 16'h9696, 1'b0, '0}
    };

    shortest_job_first_picker #(
        .DEPTH     (DEPTH),
        .PID_BITS  (PID_W),
        .TIME_BITS (TIME_W)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cur_valid     (cur_valid),
        .cur_state     (cur_state),
        .cur_pid       (cur_pid),
        .cur_remaining (cur_remaining),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sel_valid     (sel_valid),
        .sel_pid       (sel_pid),
        .sel_remaining (sel_remaining),
        .disposition   (disposition),
        .overflow      (overflow)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Append a ready task, then take the entry with the least remaining
    // time; the oldest entry wins a tie
    function automatic pick_t pick_shortest(input logic leaving, input logic [1:0] exit_state,
                                            input logic [PID_W-1:0] pid,
                                            input logic [TIME_W-1:0] remaining);
        pick_t res;
        int    best;
        res = '0;
        res.disposition = DISP_NONE;
        if (leaving)
        begin
            case (exit_state)
                EXIT_READY:
                begin
                    res.disposition = DISP_READY;
                    if (ready_len < DEPTH)
                    begin
                        ready_pid[ready_len] = pid;
                        ready_rem[ready_len] = remaining;
                        ready_len++;
                    end
                    else
                        res.overflow = 1'b1;
                end
                EXIT_BLOCKED:  res.disposition = DISP_BLOCKED;
                EXIT_FINISHED: res.disposition = DISP_FINISHED;
                default:       res.disposition = DISP_BAD;
            endcase
        end
        if (ready_len > 0)
        begin
            best = 0;
            for (int i = 1; i < ready_len; i++)
                if (ready_rem[i] < ready_rem[best])
                    best = i;
            res.sel_valid     = 1'b1;
            res.sel_pid       = ready_pid[best];
            res.sel_remaining = ready_rem[best];
            for (int i = best; i + 1 < ready_len; i++)
            begin
                ready_pid[i] = ready_pid[i + 1];
                ready_rem[i] = ready_rem[i + 1];
            end
            ready_len--;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input pick_t want, input pick_t got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $write("%0t: %s: expected valid=%0b pid=%h rem=%h disp=%0d ovf=%0b,",
                   $realtime, what, want.sel_valid, want.sel_pid, want.sel_remaining,
                   want.disposition, want.overflow);
            $display(" got valid=%0b pid=%h rem=%h disp=%0d ovf=%0b",
                     got.sel_valid, got.sel_pid, got.sel_remaining, got.disposition,
                     got.overflow);
        end
    endtask

    // Check results, record accepted calls and offer the next one
    always @(posedge clk)
    begin
        pick_t got;
        pick_t want;
        pick_t predicted;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            // compare a taken result with the oldest expectation
            if (out_valid && !out_stall)
            begin
                got = '{sel_valid, sel_pid, sel_remaining, disposition, overflow};
                if (picks_due.size() == 0)
                    report_mismatch("unexpected result", '0, got);
                else
                begin
                    want = picks_due.pop_front();
                    if (got.sel_valid !== want.sel_valid || got.sel_pid !== want.sel_pid ||
                        got.sel_remaining !== want.sel_remaining ||
                        got.disposition !== want.disposition || got.overflow !== want.overflow)
                        report_mismatch("result mismatch", want, got);
                end
            end

            // predict the result of an accepted call
            if (in_valid && !in_stall)
            begin
                predicted = pick_shortest(cur_valid, cur_state, cur_pid, cur_remaining);
                picks_due.push_back(call_held.has_pick ? call_held.pick : predicted);
            end

            // hold a stalled item, otherwise idle or offer the next one
            if (in_valid && in_stall)
                ;
            else if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (call_idx < call_q.size())
            begin
                call_held      = call_q[call_idx];
                call_idx++;
                in_valid      <= 1'b1;
                cur_valid     <= call_held.cur_valid;
                cur_state     <= call_held.cur_state;
                cur_pid       <= call_held.cur_pid;
                cur_remaining <= call_held.cur_remaining;
                if (burst_left <= 1)
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        burst_left = 200;
                        gap_left   = 0;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
                else
                    burst_left--;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Stall the result side on a rotating pattern, changed every span
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (stall_span == 0)
            begin
                stall_span  = $urandom_range(16, 160);
                stall_phase = 4'd0;
                case ($urandom_range(0, 3))
                    0:       stall_pattern = 16'h0000;
                    1:       stall_pattern = 16'($urandom & $urandom);
                    2:       stall_pattern = 16'($urandom);
                    default: stall_pattern = 16'($urandom | $urandom) & 16'hfffe;
                endcase
            end
            stall_span--;
            out_stall   <= stall_pattern[stall_phase];
            stall_phase = stall_phase + 4'd1;
        end
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        sched_call_t one_call;
        int          state_pick;
        bit          timed_out;

        // walk the directed table
        for (int i = 0; i < N_TABLE; i++)
            call_q.push_back(call_table[i]);

        // random calls: mostly leaving tasks, ready the commonest exit
        for (int i = 0; i < N_RANDOM; i++)
        begin
            one_call           = '0;
            one_call.cur_valid = ($urandom_range(0, 4) != 0);
            state_pick         = $urandom_range(0, 5);
            case (state_pick)
                0, 1, 2: one_call.cur_state = EXIT_READY;
                3:       one_call.cur_state = EXIT_BLOCKED;
                4:       one_call.cur_state = EXIT_FINISHED;
                default: one_call.cur_state = EXIT_INVALID;
            endcase
            one_call.cur_pid = PID_W'($urandom);
            case ($urandom_range(0, 7))
                0:       one_call.cur_remaining = '0;
                1:       one_call.cur_remaining = '1;
                2:       one_call.cur_remaining = TIME_W'($urandom_range(0, 15));
                default: one_call.cur_remaining = TIME_W'($urandom);
            endcase
            call_q.push_back(one_call);
        end

        // hold reset, then release it on a clock edge
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // wait for all calls to be taken and all results to arrive
        timed_out = 1'b0;
        while (!(call_idx == call_q.size() && !in_valid && picks_due.size() == 0))
        begin
            @(posedge clk);
            if (cycle_count >= MAX_CYCLE)
            begin
                timed_out = 1'b1;
                break;
            end
        end

        if (timed_out)
            $display("Mismatches found");
        else
        begin
            // let any stray result show up
            repeat (LATENCY + 32) @(posedge clk);
            mismatches += picks_due.size();
            if (mismatches == 0)
                $display("No mismatches found");
            else
                $display("Mismatches found");
        end
        $finish;
    end

endmodule
